// ===== src/value_noise_2d_turbulence_top_assert.svh =====
// Assertion macros used by the checker file of the noise block
`ifndef VALUE_NOISE_2D_TURBULENCE_TOP_ASSERT_SVH
`define VALUE_NOISE_2D_TURBULENCE_TOP_ASSERT_SVH

// property checked outside reset
`define VN2T_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("vn2t assertion failed");

// property checked at every edge, reset included
`define VN2T_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) else $error("vn2t assertion failed");

`endif

// ===== src/vn2t_pkg.sv =====
// Types and constants shared by the value noise turbulence block
package vn2t_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int FRAC_BITS  = 16;
	localparam int COORD_W    = IDX_W + FRAC_BITS;
	localparam int OCTAVE_MAX = 8;
	localparam int CNT_W      = 4;
	localparam int W_W        = 23;
	localparam int TOT_W      = 26;
	localparam int PROD_W     = 40;
	localparam int ACC_W      = 42;
	localparam int MAG_W      = 41;
	localparam int Q_BITS     = 15;

	localparam logic [1:0] REQ_PERM  = 2'd0;
	localparam logic [1:0] REQ_VALUE = 2'd1;
	localparam logic [1:0] REQ_EVAL  = 2'd2;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_OCT  = 2'd1;
	localparam logic [1:0] CFG_LAC  = 2'd2;
	localparam logic [1:0] CFG_GAIN = 2'd3;

	localparam logic [W_W-1:0] W_ONE = W_W'(32768);

	typedef struct packed {
		logic [1:0]         kind;
		logic [IDX_W-1:0]   idx;
		logic [15:0]        val;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [W_W-1:0]     w;
		logic               first;
		logic               last;
		logic               turb;
	} job_t;

	typedef struct packed {
		logic                     eval;
		logic                     first;
		logic                     last;
		logic                     turb;
		logic [W_W-1:0]           w;
		logic signed [15:0]       smp;
		logic signed [PROD_W-1:0] prod;
	} smp_t;

endpackage

// ===== src/vn2t_front.sv =====
// Request decode and octave sequencer feeding the sample pipeline
module vn2t_front import vn2t_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	output logic               in_rdy,
	input  logic [1:0]         in_req,
	input  logic [IDX_W-1:0]   in_idx,
	input  logic [15:0]        in_val,
	input  logic [COORD_W-1:0] in_x,
	input  logic [COORD_W-1:0] in_y,
	input  logic               mode,
	input  logic [CNT_W-1:0]   oct,
	input  logic [15:0]        lac,
	input  logic [15:0]        gain,
	output logic               job_v,
	output job_t               job
);

	logic               busy_q;
	logic [CNT_W-1:0]   left_q;
	logic [COORD_W-1:0] cx_q, cy_q;
	logic [W_W-1:0]     w_q;
	logic               v_s1;
	job_t               job_s1;

	logic [CNT_W-1:0]   n_eff;
	logic               accept, turb_in, known, emit;
	logic [COORD_W-1:0] cur_x, cur_y;
	logic [W_W-1:0]     cur_w;
	logic [39:0]        x_prod, y_prod;
	logic [38:0]        w_prod;
	job_t               job_nxt;

	assign in_rdy  = en && !busy_q;
	assign accept  = in_v && in_rdy;
	assign turb_in = mode && (in_req == REQ_EVAL);
	assign known   = (in_req == REQ_PERM) || (in_req == REQ_VALUE) || (in_req == REQ_EVAL);
	assign emit    = busy_q || (accept && known);

	always_comb begin
		if (oct == '0) begin
			n_eff = CNT_W'(1);
		end else if (oct > CNT_W'(OCTAVE_MAX)) begin
			n_eff = CNT_W'(OCTAVE_MAX);
		end else begin
			n_eff = oct;
		end
	end

	assign cur_x  = busy_q ? cx_q : in_x;
	assign cur_y  = busy_q ? cy_q : in_y;
	assign cur_w  = busy_q ? w_q : W_ONE;
	// next octave: coordinate * lacunarity (Q4.12), weight * gain (Q1.15)
	assign x_prod = cur_x * lac;
	assign y_prod = cur_y * lac;
	assign w_prod = cur_w * gain;

	always_comb begin
		job_nxt.kind  = busy_q ? REQ_EVAL : in_req;
		job_nxt.idx   = in_idx;
		job_nxt.val   = in_val;
		job_nxt.cx    = cur_x;
		job_nxt.cy    = cur_y;
		job_nxt.w     = cur_w;
		job_nxt.first = !busy_q;
		job_nxt.last  = busy_q ? (left_q == CNT_W'(1)) : (!turb_in || n_eff == CNT_W'(1));
		job_nxt.turb  = busy_q || turb_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
			v_s1   <= 1'b0;
		end else if (en) begin
			v_s1 <= emit;
			if (busy_q) begin
				left_q <= left_q - CNT_W'(1);
				busy_q <= (left_q != CNT_W'(1));
			end else if (accept && turb_in && n_eff != CNT_W'(1)) begin
				left_q <= n_eff - CNT_W'(1);
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s1 <= job_nxt;
			cx_q   <= x_prod[COORD_W+11:12];
			cy_q   <= y_prod[COORD_W+11:12];
			w_q    <= w_prod[W_W+14:15];
		end
	end

	assign job_v = v_s1;
	assign job   = job_s1;

endmodule

// ===== src/vn2t_sample.sv =====
// Single-octave value noise pipeline: hashing, table reads, fade and bilinear blend
module vn2t_sample import vn2t_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  job_t in_job,
	output logic out_v,
	output smp_t out_smp
);

	function automatic logic signed [15:0] blend(input logic signed [15:0] a,
			input logic signed [15:0] b, input logic [16:0] f);
		logic signed [16:0] d;
		logic signed [35:0] m;
		logic signed [35:0] s;
		d = 17'(b) - 17'(a);
		m = d * $signed({1'b0, f});
		s = {{4{a[15]}}, a, 16'd0} + m + 36'sd32768;
		return s[31:16];
	endfunction

	// table copies, each written in the stage that reads it, so each sees writes in request order
	logic [IDX_W-1:0]   perm_a [TABLE_SIZE];
	logic [IDX_W-1:0]   perm_b [TABLE_SIZE];
	logic [IDX_W-1:0]   perm_c [TABLE_SIZE];
	logic signed [15:0] val_a  [TABLE_SIZE];
	logic signed [15:0] val_b  [TABLE_SIZE];

	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	job_t job_s2, job_s3, job_s4, job_s5, job_s6, job_s7;

	logic [IDX_W-1:0]   pix0_s2, pix1_s2;
	logic [15:0]        tx2_s2, ty2_s2;
	logic [IDX_W-1:0]   aa_s3, ab_s3, ba_s3, bb_s3;
	logic [15:0]        t3x_s3, t3y_s3;
	logic [20:0]        qx_s3, qy_s3;
	logic signed [15:0] vaa_s4, vab_s4, vba_s4, vbb_s4;
	logic [16:0]        fx_s4, fy_s4;
	logic signed [15:0] lo_s5, hi_s5;
	logic [16:0]        fy_s5;
	logic signed [15:0] smp_s6, smp_s7;
	logic signed [PROD_W-1:0] prod_s7;

	logic [IDX_W-1:0] ix, ix1, iy2, ha, ha1, hb, hb1;
	logic [31:0]      tx2, ty2, t3x, t3y;
	logic [20:0]      qx, qy;
	logic [36:0]      fxp, fyp;
	logic [20:0]      fxs, fys;
	logic [16:0]      fx, fy;
	logic signed [PROD_W-1:0] prod;

	assign ix  = in_job.cx[COORD_W-1:FRAC_BITS];
	assign ix1 = ix + IDX_W'(1);
	assign tx2 = in_job.cx[15:0] * in_job.cx[15:0];
	assign ty2 = in_job.cy[15:0] * in_job.cy[15:0];

	assign iy2 = job_s2.cy[COORD_W-1:FRAC_BITS];
	assign ha  = pix0_s2 + iy2;
	assign ha1 = ha + IDX_W'(1);
	assign hb  = pix1_s2 + iy2;
	assign hb1 = hb + IDX_W'(1);
	assign t3x = tx2_s2 * job_s2.cx[15:0];
	assign t3y = ty2_s2 * job_s2.cy[15:0];
	// 6t^2 - 15t + 10 stays positive over the whole fraction range
	assign qx  = 21'd655360 + 21'(tx2_s2) * 21'd6 - 21'(job_s2.cx[15:0]) * 21'd15;
	assign qy  = 21'd655360 + 21'(ty2_s2) * 21'd6 - 21'(job_s2.cy[15:0]) * 21'd15;

	assign fxp = t3x_s3 * qx_s3;
	assign fyp = t3y_s3 * qy_s3;
	assign fxs = fxp[36:16];
	assign fys = fyp[36:16];
	assign fx  = (fxs > 21'd65536) ? 17'd65536 : fxs[16:0];
	assign fy  = (fys > 21'd65536) ? 17'd65536 : fys[16:0];

	assign prod = $signed({1'b0, job_s6.w}) * smp_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s2 <= in_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (in_v && in_job.kind == REQ_PERM) begin
				perm_a[in_job.idx] <= in_job.val[IDX_W-1:0];
			end
			pix0_s2 <= perm_a[ix];
			pix1_s2 <= perm_a[ix1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s2 && job_s2.kind == REQ_PERM) begin
				perm_b[job_s2.idx] <= job_s2.val[IDX_W-1:0];
			end
			aa_s3 <= perm_b[ha];
			ab_s3 <= perm_b[ha1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s2 && job_s2.kind == REQ_PERM) begin
				perm_c[job_s2.idx] <= job_s2.val[IDX_W-1:0];
			end
			ba_s3 <= perm_c[hb];
			bb_s3 <= perm_c[hb1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s3 && job_s3.kind == REQ_VALUE) begin
				val_a[job_s3.idx] <= job_s3.val;
			end
			vaa_s4 <= val_a[aa_s3];
			vba_s4 <= val_a[ba_s3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s3 && job_s3.kind == REQ_VALUE) begin
				val_b[job_s3.idx] <= job_s3.val;
			end
			vab_s4 <= val_b[ab_s3];
			vbb_s4 <= val_b[bb_s3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s2  <= in_job;
			tx2_s2  <= tx2[31:16];
			ty2_s2  <= ty2[31:16];
			job_s3  <= job_s2;
			t3x_s3  <= t3x[31:16];
			t3y_s3  <= t3y[31:16];
			qx_s3   <= qx;
			qy_s3   <= qy;
			job_s4  <= job_s3;
			fx_s4   <= fx;
			fy_s4   <= fy;
			job_s5  <= job_s4;
			lo_s5   <= blend(vaa_s4, vba_s4, fx_s4);
			hi_s5   <= blend(vab_s4, vbb_s4, fx_s4);
			fy_s5   <= fy_s4;
			job_s6  <= job_s5;
			smp_s6  <= blend(lo_s5, hi_s5, fy_s5);
			job_s7  <= job_s6;
			smp_s7  <= smp_s6;
			prod_s7 <= prod;
		end
	end

	assign out_v         = v_s7;
	assign out_smp.eval  = (job_s7.kind == REQ_EVAL);
	assign out_smp.first = job_s7.first;
	assign out_smp.last  = job_s7.last;
	assign out_smp.turb  = job_s7.turb;
	assign out_smp.w     = job_s7.w;
	assign out_smp.smp   = smp_s7;
	assign out_smp.prod  = prod_s7;

endmodule

// ===== src/vn2t_div.sv =====
// Octave accumulation, magnitude and pipelined restoring divide by total weight
module vn2t_div import vn2t_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  smp_t               in_smp,
	output logic               out_v,
	output logic signed [15:0] out_noise,
	output logic               out_sat
);

	typedef struct packed {
		logic               turb;
		logic               sat;
		logic signed [15:0] smp;
		logic [MAG_W-1:0]   rem;
		logic [TOT_W-1:0]   tot;
		logic [Q_BITS-1:0]  quo;
	} dv_t;

	logic signed [ACC_W-1:0] acc_q;
	logic [TOT_W-1:0]        tot_q;

	logic                    v_s8, v_s9;
	logic signed [ACC_W-1:0] sum_s8;
	logic [TOT_W-1:0]        tot_s8, tot_s9;
	logic signed [15:0]      smp_s8, smp_s9;
	logic                    turb_s8, turb_s9;
	logic [MAG_W-1:0]        mag_s9;

	logic                    dv_v_s [Q_BITS+1];
	dv_t                     dv_s   [Q_BITS+1];

	logic signed [ACC_W-1:0] acc_nxt, neg;
	logic [TOT_W-1:0]        tot_nxt;

	assign acc_nxt = in_smp.first ? ACC_W'(in_smp.prod) : acc_q + ACC_W'(in_smp.prod);
	assign tot_nxt = in_smp.first ? TOT_W'(in_smp.w) : tot_q + TOT_W'(in_smp.w);
	assign neg     = -sum_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			if (in_v && in_smp.eval) begin
				acc_q <= acc_nxt;
				tot_q <= tot_nxt;
			end
			sum_s8  <= acc_nxt;
			tot_s8  <= tot_nxt;
			smp_s8  <= in_smp.smp;
			turb_s8 <= in_smp.turb;
			mag_s9  <= sum_s8[ACC_W-1] ? neg[MAG_W-1:0] : sum_s8[MAG_W-1:0];
			tot_s9  <= tot_s8;
			smp_s9  <= smp_s8;
			turb_s9 <= turb_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s8      <= in_v && in_smp.eval && in_smp.last;
			v_s9      <= v_s8;
			dv_v_s[0] <= v_s9;
		end
	end

	// quotient above 15 bits means |sum| >= total * 2^15
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].turb <= turb_s9;
			dv_s[0].sat  <= (mag_s9 >= {tot_s9, {Q_BITS{1'b0}}});
			dv_s[0].smp  <= smp_s9;
			dv_s[0].rem  <= mag_s9;
			dv_s[0].tot  <= tot_s9;
			dv_s[0].quo  <= '0;
		end
	end

	for (genvar i = 0; i < Q_BITS; i++) begin : g_div
		logic [MAG_W-1:0] dsr;
		logic             fit;
		dv_t              nxt;

		assign dsr = MAG_W'(dv_s[i].tot) << (Q_BITS - 1 - i);
		assign fit = (dv_s[i].rem >= dsr);

		always_comb begin
			nxt = dv_s[i];
			if (fit) begin
				nxt.rem = dv_s[i].rem - dsr;
				nxt.quo[Q_BITS-1-i] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[i+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[i+1] <= dv_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[i+1] <= nxt;
			end
		end
	end

	assign out_v     = dv_v_s[Q_BITS];
	assign out_sat   = dv_s[Q_BITS].turb && dv_s[Q_BITS].sat;
	assign out_noise = !dv_s[Q_BITS].turb ? dv_s[Q_BITS].smp :
		(dv_s[Q_BITS].sat ? 16'sh7FFF : $signed({1'b0, dv_s[Q_BITS].quo}));

endmodule

// ===== src/value_noise_2d_turbulence_top.sv =====
// Top level of the 2D value noise / turbulence generator
// One request enters per cycle in single-sample mode while the output is not stalled.
// In turbulence mode a point holds the input until its N octaves, N being
// octave_count limited to 1..8, have been issued by the octave sequencer, which
// issues one octave per cycle into the shared sample pipeline unless the output stalls.
// m_tvalid rises once the request carrying the last octave has passed the sample
// pipeline, the divider and the output register. Table writes travel the same
// pipeline, so they take effect in request order and give no result; the permutation
// table is held as three copies and the value table as two, each written at the stage that reads it.
module value_noise_2d_turbulence_top import vn2t_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // table_index[7:0], table_value[23:8], x_coord[47:24], y_coord[71:48]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // noise_value[15:0]
	output logic        m_tuser,   // saturated[0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic             mode_q;
	logic [CNT_W-1:0] oct_q;
	logic [15:0]      lac_q, gain_q;

	logic               en;
	logic               job_v, smp_v, res_v;
	job_t               job;
	smp_t               smp;
	logic signed [15:0] res_noise;
	logic               res_sat;

	logic        out_v_q, skid_v_q;
	logic [15:0] out_noise_q, skid_noise_q;
	logic        out_sat_q, skid_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			oct_q  <= CNT_W'(4);
			lac_q  <= 16'd8192;
			gain_q <= 16'd16384;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_OCT:  oct_q  <= cfg_data[CNT_W-1:0];
				CFG_LAC:  lac_q  <= cfg_data;
				CFG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the whole pipeline moves unless the skid slot is occupied
	assign en = !skid_v_q;

	vn2t_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (s_tvalid),
		.in_rdy (s_tready),
		.in_req (s_tuser),
		.in_idx (s_tdata[7:0]),
		.in_val (s_tdata[23:8]),
		.in_x   (s_tdata[47:24]),
		.in_y   (s_tdata[71:48]),
		.mode   (mode_q),
		.oct    (oct_q),
		.lac    (lac_q),
		.gain   (gain_q),
		.job_v  (job_v),
		.job    (job)
	);

	vn2t_sample u_sample (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (job_v),
		.in_job  (job),
		.out_v   (smp_v),
		.out_smp (smp)
	);

	vn2t_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_v      (smp_v),
		.in_smp    (smp),
		.out_v     (res_v),
		.out_noise (res_noise),
		.out_sat   (res_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (res_v) begin
			if (out_v_q && !m_tready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready) begin
				out_noise_q <= skid_noise_q;
				out_sat_q   <= skid_sat_q;
			end
		end else if (res_v) begin
			if (out_v_q && !m_tready) begin
				skid_noise_q <= res_noise;
				skid_sat_q   <= res_sat;
			end else begin
				out_noise_q <= res_noise;
				out_sat_q   <= res_sat;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_noise_q;
	assign m_tuser  = out_sat_q;

endmodule

// ===== src/vn2t_checker.sv =====
// Port-level checks for the noise block, bound to its top level
`include "value_noise_2d_turbulence_top_assert.svh"

module vn2t_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// a clamped magnitude is always the largest positive code
	`VN2T_ASSERT(a_sat_clamp, clk, arst_n, m_tvalid && m_tuser |-> m_tdata == 16'h7FFF)

	// a stalled result holds
	`VN2T_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// no result shows while reset is applied
	`VN2T_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !m_tvalid)

endmodule

bind value_noise_2d_turbulence_top vn2t_checker u_vn2t_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
